### src/vgm_opl_command_parser_core_defines.svh
// ----------------------------------------------------------------------------
// vgm opl command parser assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef VGM_OPL_COMMAND_PARSER_CORE_DEFINES_SVH
`define VGM_OPL_COMMAND_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define VOCP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vocp assertion failed");

// next-cycle implication
`define VOCP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vocp assertion failed");

`endif

### src/vocp_pkg.sv
// ----------------------------------------------------------------------------
// vocp_pkg
// types and constants shared by the vgm command parser modules
// ----------------------------------------------------------------------------
package vocp_pkg;

  // stream command bytes
  localparam logic [7:0] CmdRegWrite = 8'h5A;
  localparam logic [7:0] CmdWaitN    = 8'h61;
  localparam logic [7:0] CmdWaitNtsc = 8'h62;
  localparam logic [7:0] CmdWaitPal  = 8'h63;
  localparam logic [7:0] CmdEnd      = 8'h66;
  localparam logic [3:0] CmdShortHi  = 4'h7;

  localparam logic [15:0] WaitNtsc = 16'd735;
  localparam logic [15:0] WaitPal  = 16'd882;

  localparam logic [16:0] SamplesPerSec = 17'd44100;
  localparam logic [16:0] TwoSeconds    = 17'd88200;
  localparam logic [9:0]  SecondsMax    = 10'd1023;
  localparam logic [9:0]  MaxSecReset   = 10'd999;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_END   = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_data;
    logic [15:0] wait_samples;
    logic        play_stopped;
  } out_item_t;

  // decoded command passed from front to back
  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   addr;
    logic [7:0]   data;
    logic [15:0]  wait_len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### src/vgm_opl_command_parser_core.sv
// ----------------------------------------------------------------------------
// vgm_opl_command_parser_core
// vgm command stream parser: register writes, waits, end of song, play limit
// ----------------------------------------------------------------------------
// Feed the stream one byte per request; a new byte is taken every cycle
// while the downstream takes results, so the sustained rate is one byte
// per clock. A byte that completes a command is written into the command
// queue, then taken by the accounting stage into its output register. The
// two-entry queue lets the decoder keep taking bytes while the output is
// stalled, until the queue fills; in_stall_o rises only when that queue is
// full. Commands that take more bytes (register write, 16-bit wait) give no
// result on their earlier bytes, and unknown bytes are skipped. Once play
// stops (end tag, last byte or the second limit) every later byte is accepted
// and dropped until reset. max_play_seconds is written through cfg_we_i /
// cfg_data_i by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module vgm_opl_command_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // stream byte requests
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vocp_pkg::in_item_t  in_data_i,
  // result requests
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vocp_pkg::out_item_t out_data_o,
  // max_play_seconds register
  input  logic                cfg_we_i,
  input  logic [9:0]          cfg_data_i
);
  import vocp_pkg::*;

  logic      [9:0] max_sec_q;
  logic            in_accept;
  logic            push;
  logic            pop;
  cmd_t            front_cmd;
  cmd_t            head_cmd;
  q_status_t       q_status;

  // stall only on a full queue, never on the output side directly
  assign in_stall_o = q_status.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  // second limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sec_q <= MaxSecReset;
    end else if (cfg_we_i) begin
      max_sec_q <= cfg_data_i;
    end
  end

  // decoder: phase tracking and command classification
  vocp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .in_i     (in_data_i),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  // decoupling queue
  vocp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  // accounting and output register
  vocp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_sec_i   (max_sec_q),
    .cmd_i       (head_cmd),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_data_o)
  );

endmodule

### src/vocp_front.sv
// ----------------------------------------------------------------------------
// vocp_front
// byte-level command decoder: tracks the parse phase, emits decoded commands
// ----------------------------------------------------------------------------
module vocp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  vocp_pkg::in_item_t in_i,
  output logic               push_o,
  output vocp_pkg::cmd_t     cmd_o
);
  import vocp_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_WR_ADDR = 5'b00010,
    PH_WR_DATA = 5'b00100,
    PH_WAIT_LO = 5'b01000,
    PH_WAIT_HI = 5'b10000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic       live_q, live_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] wlo_q, wlo_d;
  logic [7:0] b;

  assign b = in_i.stream_byte;

  always_comb begin
    phase_d = phase_q;
    live_d  = live_q;
    addr_d  = addr_q;
    wlo_d   = wlo_q;
    push_o  = 1'b0;
    cmd_o   = '{kind: KIND_WRITE, addr: 8'd0, data: 8'd0, wait_len: 16'd0};
    if (accept_i && live_q) begin
      unique case (phase_q)
        PH_WR_ADDR: begin
          addr_d  = b;
          phase_d = PH_WR_DATA;
        end
        PH_WR_DATA: begin
          push_o     = 1'b1;
          cmd_o.addr = addr_q;
          cmd_o.data = b;
          phase_d    = PH_IDLE;
        end
        PH_WAIT_LO: begin
          wlo_d   = b;
          phase_d = PH_WAIT_HI;
        end
        PH_WAIT_HI: begin
          push_o         = 1'b1;
          cmd_o.kind     = KIND_WAIT;
          cmd_o.wait_len = {b, wlo_q};
          phase_d        = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
          priority if (b == CmdRegWrite) begin
            phase_d = PH_WR_ADDR;
          end else if (b == CmdWaitN) begin
            phase_d = PH_WAIT_LO;
          end else if (b == CmdWaitNtsc) begin
            push_o         = 1'b1;
            cmd_o.kind     = KIND_WAIT;
            cmd_o.wait_len = WaitNtsc;
          end else if (b == CmdWaitPal) begin
            push_o         = 1'b1;
            cmd_o.kind     = KIND_WAIT;
            cmd_o.wait_len = WaitPal;
          end else if (b == CmdEnd) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_END;
            live_d     = 1'b0;
          end else if (b[7:4] == CmdShortHi) begin
            push_o         = 1'b1;
            cmd_o.kind     = KIND_WAIT;
            cmd_o.wait_len = 16'({12'd0, b[3:0]} + 16'd1);
          end else begin
            // unknown byte, skip
            phase_d = PH_IDLE;
          end
        end
      endcase
    end
    if (accept_i && in_i.stream_last) begin
      live_d  = 1'b0;
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      live_q  <= 1'b1;
    end else begin
      phase_q <= phase_d;
      live_q  <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    wlo_q  <= wlo_d;
  end

endmodule

### src/vocp_queue.sv
// ----------------------------------------------------------------------------
// vocp_queue
// two-entry command queue between decoder and accounting stage
// ----------------------------------------------------------------------------
module vocp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vocp_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output vocp_pkg::cmd_t      cmd_o,
  output vocp_pkg::q_status_t status_o
);
  import vocp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign cmd_o          = mem_q[rd_q];
  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

endmodule

### src/vocp_back.sv
// ----------------------------------------------------------------------------
// vocp_back
// wait accounting, second limit, play state and registered result output
// ----------------------------------------------------------------------------
`include "vgm_opl_command_parser_core_defines.svh"

module vocp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [9:0]          max_sec_i,
  input  vocp_pkg::cmd_t      cmd_i,
  input  vocp_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vocp_pkg::out_item_t out_o
);
  import vocp_pkg::*;

  logic [16:0] frac_q, frac_d;
  logic [9:0]  sec_q, sec_d;
  logic        playing_q, playing_d;
  logic        valid_q, valid_d;
  out_item_t   out_q, out_d;
  logic [16:0] sum;
  logic [1:0]  ticks;
  logic [10:0] sec_sum;
  logic        stop;

  assign pop_o       = !q_status_i.empty && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_o       = out_q;

  // up to two second ticks per wait, fraction stays below one second
  always_comb begin
    sum = frac_q + {1'b0, cmd_i.wait_len};
    priority if (sum >= TwoSeconds) begin
      ticks  = 2'd2;
      frac_d = sum - TwoSeconds;
    end else if (sum >= SamplesPerSec) begin
      ticks  = 2'd1;
      frac_d = sum - SamplesPerSec;
    end else begin
      ticks  = 2'd0;
      frac_d = sum;
    end
    sec_sum = {1'b0, sec_q} + {9'd0, ticks};
    sec_d   = (sec_sum > {1'b0, SecondsMax}) ? SecondsMax : sec_sum[9:0];
    stop    = (ticks != 2'd0) && !(sec_d < max_sec_i);
  end

  always_comb begin
    playing_d = playing_q;
    valid_d   = valid_q && out_stall_i;
    out_d     = out_q;
    if (pop_o && playing_q) begin
      valid_d           = 1'b1;
      out_d.result_kind = cmd_i.kind;
      out_d.reg_addr    = 8'd0;
      out_d.reg_data    = 8'd0;
      out_d.wait_samples = 16'd0;
      out_d.play_stopped = 1'b0;
      unique case (cmd_i.kind)
        KIND_WRITE: begin
          out_d.reg_addr = cmd_i.addr;
          out_d.reg_data = cmd_i.data;
        end
        KIND_WAIT: begin
          out_d.wait_samples = cmd_i.wait_len;
          out_d.play_stopped = stop;
          if (stop) playing_d = 1'b0;
        end
        KIND_END: begin
          out_d.play_stopped = 1'b1;
          playing_d          = 1'b0;
        end
        default: valid_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q    <= 17'd0;
      sec_q     <= 10'd0;
      playing_q <= 1'b1;
      valid_q   <= 1'b0;
    end else begin
      if (pop_o && playing_q && (cmd_i.kind == KIND_WAIT)) begin
        frac_q <= frac_d;
        sec_q  <= sec_d;
      end
      playing_q <= playing_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  `VOCP_ASSERT_NXT(a_stop_sticky, !playing_q, !playing_q)
  `VOCP_ASSERT_NXT(a_drop_after_stop, pop_o && !playing_q, !valid_q)
  `VOCP_ASSERT_NXT(a_end_stops, pop_o && playing_q && (cmd_i.kind == KIND_END), !playing_q)
  `VOCP_ASSERT_NXT(a_sec_monotonic, 1'b1, sec_q >= $past(sec_q))

endmodule

### dv/vgm_opl_command_parser_core_tb.sv
// ----------------------------------------------------------------------------
// vgm_opl_command_parser_core_tb
// self-checking bench for the vgm command stream parser: a directed pass over
// every command, wait corner and unknown byte, then random command streams
// under several play limits, and one randomly picked way of ending play,
// checked result by result against a predictor kept inside the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgm_opl_command_parser_core_tb;
  import vocp_pkg::*;

  localparam int HoldOffCycles = 400;   // long receiver hold-off
  localparam int WatchdogLimit = 3000;  // cycles with no request moving
  localparam int SettleCycles  = 8;     // pipeline depth plus margin
  localparam int PhaseCommands = 65;    // commands per random phase

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_ADDR,
    ST_WR_DATA,
    ST_WAIT_LO,
    ST_WAIT_HI
  } parse_state_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_item_t  out_data_o;
  logic       cfg_we_i;
  logic [9:0] cfg_data_i;

  vgm_opl_command_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // parser copy: phase, held bytes, sample accounting and the play limit
  // --------------------------------------------------------------------------
  parse_state_e parse_st;
  logic [7:0]   held_addr;
  logic [7:0]   held_wait_lo;
  int unsigned  sample_frac;
  logic [9:0]   secs_played;
  bit           playing;
  logic [9:0]   max_secs;

  out_item_t    expected_results[$];
  out_item_t    oldest_result;
  int           err_cnt;
  int           burst_left;
  int           idle_cycles;
  bit           hold_req;

  // sums a wait into the fraction, ticking whole seconds; the limit is only
  // looked at when a second ticks, and the counter saturates
  task automatic account_wait(input logic [15:0] len, output out_item_t res);
    res = '0;
    res.result_kind  = KIND_WAIT;
    res.wait_samples = len;
    sample_frac += len;
    while (sample_frac >= SamplesPerSec) begin
      sample_frac -= SamplesPerSec;
      if (secs_played < SecondsMax) secs_played++;
      if (!(secs_played < max_secs) && playing) begin
        playing = 1'b0;
        res.play_stopped = 1'b1;
      end
    end
  endtask

  // one accepted stream byte; at most one result comes of it
  task automatic decode_stream_byte(input logic [7:0] b, input logic is_last,
                                    output bit has_res, output out_item_t res);
    has_res = 1'b0;
    res     = '0;
    if (!playing) return;   // dead until reset once play has stopped
    case (parse_st)
      ST_WR_ADDR: begin
        held_addr = b;
        parse_st  = ST_WR_DATA;
      end
      ST_WR_DATA: begin
        res.result_kind = KIND_WRITE;
        res.reg_addr    = held_addr;
        res.reg_data    = b;
        has_res         = 1'b1;
        parse_st        = ST_IDLE;
      end
      ST_WAIT_LO: begin
        held_wait_lo = b;
        parse_st     = ST_WAIT_HI;
      end
      ST_WAIT_HI: begin
        parse_st = ST_IDLE;
        account_wait({b, held_wait_lo}, res);
        has_res  = 1'b1;
      end
      default: begin
        parse_st = ST_IDLE;
        if (b == CmdRegWrite) begin
          parse_st = ST_WR_ADDR;
        end else if (b == CmdWaitN) begin
          parse_st = ST_WAIT_LO;
        end else if (b == CmdWaitNtsc) begin
          account_wait(WaitNtsc, res);
          has_res = 1'b1;
        end else if (b == CmdWaitPal) begin
          account_wait(WaitPal, res);
          has_res = 1'b1;
        end else if (b == CmdEnd) begin
          playing          = 1'b0;
          res.result_kind  = KIND_END;
          res.play_stopped = 1'b1;
          has_res          = 1'b1;
        end else if (b[7:4] == CmdShortHi) begin
          account_wait(16'(b[3:0]) + 16'd1, res);
          has_res = 1'b1;
        end
        // anything else is skipped
      end
    endcase
    // last byte ends play; an unfinished command is dropped
    if (is_last) begin
      playing  = 1'b0;
      parse_st = ST_IDLE;
    end
  endtask

  // --------------------------------------------------------------------------
  // sender: one stream byte per call, in bursts with random gaps
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int        gap;
    bit        has_res;
    out_item_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{stream_byte: b, stream_last: is_last};
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    decode_stream_byte(b, is_last, has_res, res);
    if (has_res) expected_results.push_back(res);
  endtask

  // sender pause until the block has nothing left in flight
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_seconds(input logic [9:0] value);
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    max_secs = value;
  endtask

  task automatic send_reg_write();
    send_byte(CmdRegWrite, 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
  endtask

  // a byte that is no command at all
  task automatic send_noise_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CmdRegWrite || b == CmdWaitN || b == CmdWaitNtsc ||
           b == CmdWaitPal || b == CmdEnd || b[7:4] == CmdShortHi);
    send_byte(b, 1'b0);
  endtask

  // one well-formed command with random content, or noise; waits are only
  // picked while two more second ticks cannot reach the limit
  task automatic send_random_command();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick >= 40 && int'(secs_played) + 2 >= int'(max_secs)) pick = 20;
    if (pick < 10) begin
      send_noise_byte();
    end else if (pick < 40) begin
      send_reg_write();
    end else if (pick < 65) begin
      send_byte(CmdWaitN, 1'b0);
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b0);
    end else if (pick < 75) begin
      send_byte($urandom_range(0, 1) ? CmdWaitNtsc : CmdWaitPal, 1'b0);
    end else begin
      send_byte({CmdShortHi, 4'($urandom)}, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every command but the end tag, the field extremes at the reset limit; the
  // second long wait lands on a fraction high enough to tick two seconds at once
  task automatic test_directed_commands();
    logic [7:0] seq[$] = '{
      CmdRegWrite, 8'h00, 8'h00,
      CmdRegWrite, 8'hFF, 8'hFF,
      CmdWaitN, 8'h00, 8'h00,       // zero-length wait
      CmdWaitN, 8'hFF, 8'hFF,       // longest wait, one tick
      CmdWaitNtsc, CmdWaitPal,
      CmdWaitN, 8'hFF, 8'hFF,       // two ticks in one wait
      8'h70, 8'h7F,                 // shortest and longest short waits
      8'h00, 8'hFF, 8'h67           // unknown bytes are skipped
    };
    foreach (seq[i]) send_byte(seq[i], 1'b0);
  endtask

  // lowest limit: no wait may tick here, so only writes, noise and
  // zero-length waits go in
  task automatic test_lowest_limit();
    wait_for_idle();
    write_max_seconds(10'd1);
    repeat (8) begin
      case ($urandom_range(0, 2))
        0: send_reg_write();
        1: send_noise_byte();
        default: begin
          send_byte(CmdWaitN, 1'b0);
          send_byte(8'h00, 1'b0);
          send_byte(8'h00, 1'b0);
        end
      endcase
    end
  endtask

  // random streams under several limits; one phase runs into a long
  // receiver hold-off while the sender keeps offering bytes
  task automatic test_random_streams();
    int         sent;
    logic [9:0] limit;
    for (int ph = 0; ph < 5; ph++) begin
      wait_for_idle();
      if (ph == 0) limit = SecondsMax;
      else if (ph == 4) limit = MaxSecReset;
      else limit = 10'((int'(secs_played) + $urandom_range(60, 400) > 1023) ?
                       1023 : int'(secs_played) + $urandom_range(60, 400));
      if (int'(limit) < int'(secs_played) + 3) limit = SecondsMax;
      write_max_seconds(limit);
      sent = 0;
      while (sent < PhaseCommands) begin
        if (ph == 2 && sent == 20) hold_req = 1'b1;
        send_random_command();
        sent++;
      end
    end
  endtask

  // play can stop only once per run, so the way it stops is picked at random
  task automatic test_end_of_play();
    wait_for_idle();
    case ($urandom_range(0, 3))
      0: send_byte(CmdEnd, 1'($urandom_range(0, 1)));   // end tag
      1: begin
        // second limit just above the count, long waits until it trips
        write_max_seconds(secs_played + 10'd1);
        while (playing) begin
          send_byte(CmdWaitN, 1'b0);
          send_byte(8'($urandom), 1'b0);
          send_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
        end
      end
      2: begin
        // last byte in the middle of a command: nothing comes of it
        if ($urandom_range(0, 1)) begin
          send_byte(CmdRegWrite, 1'b0);
          send_byte(8'($urandom), 1'b1);
        end else begin
          send_byte(CmdWaitN, 1'b1);
        end
      end
      default: begin
        // last byte that completes a write gives its result first
        send_byte(CmdRegWrite, 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
    endcase
  endtask

  // once stopped every byte is taken and dropped
  task automatic test_after_stop();
    repeat (20) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    send_byte(CmdEnd, 1'b0);
    send_byte(CmdWaitNtsc, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // receiver: stall pattern of its own, plus the long hold-off on request
  // --------------------------------------------------------------------------
  int stall_mode;
  int stall_run;
  int hold_left;

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run  = $urandom_range(1, 64);
      end
      stall_run--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;                              // no stalls
        1: out_stall_i <= ($urandom_range(0, 3) == 0);       // light
        2: out_stall_i <= ($urandom_range(0, 3) != 0);       // heavy
        default: out_stall_i <= stall_run[0];                // every other
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result check: each accepted result against the oldest expectation
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: %p", out_data_o);
        err_cnt++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("result_kind", oldest_result.result_kind, out_data_o.result_kind);
        check_field("reg_addr", oldest_result.reg_addr, out_data_o.reg_addr);
        check_field("reg_data", oldest_result.reg_data, out_data_o.reg_data);
        check_field("wait_samples", oldest_result.wait_samples, out_data_o.wait_samples);
        check_field("play_stopped", oldest_result.play_stopped, out_data_o.play_stopped);
      end
    end
  end

  // watchdog: too long with no request moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = '0;
    err_cnt      = 0;
    burst_left   = 0;
    idle_cycles  = 0;
    hold_req     = 1'b0;
    stall_mode   = 0;
    stall_run    = 0;
    hold_left    = 0;
    // parser copy at its reset state
    parse_st     = ST_IDLE;
    held_addr    = '0;
    held_wait_lo = '0;
    sample_frac  = 0;
    secs_played  = '0;
    playing      = 1'b1;
    max_secs     = MaxSecReset;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_commands();
    test_lowest_limit();
    test_random_streams();
    test_end_of_play();
    test_after_stop();

    // drain, then let the pipeline settle
    wait_for_idle();
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/vocp_pkg.sv
src/vocp_front.sv
src/vocp_queue.sv
src/vocp_back.sv
src/vgm_opl_command_parser_core.sv
dv/vgm_opl_command_parser_core_tb.sv
